FILE: hdl/lbs_pkg.sv
// Shared types, codes and helpers for the literal byte search unit.
// No dependencies; used by lbs_match and literal_byte_search_unit.
`default_nettype none

package lbs_pkg;

    localparam int MAX_LITERAL_DEF = 32;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int LIT_BYTES = 32;
    localparam int LIT_WORDS = 4;
    localparam int WORD_W    = 64;
    localparam int LEN_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_OFF_W = 32;

    localparam logic [7:0] HIGH_BYTE   = 8'h80;
    localparam logic [7:0] UPPER_FIRST = 8'h41;
    localparam logic [7:0] UPPER_LAST  = 8'h5A;
    localparam logic [7:0] FOLD_DIST   = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LITERAL_LENGTH   = 3'd0,
        CFG_CASE_INSENSITIVE = 3'd1,
        CFG_LIT_LOW          = 3'd2,
        CFG_LIT_SECOND       = 3'd3,
        CFG_LIT_THIRD        = 3'd4,
        CFG_LIT_HIGH         = 3'd5
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_MATCH = 2'd0,
        KIND_CLEAN = 2'd1,
        KIND_ABORT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [OUT_OFF_W-1:0]  offset;
        logic                  last;
    } t_result;

    typedef struct packed {
        logic hit;
        logic bad;
    } t_match_flags;

    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        return (b >= UPPER_FIRST && b <= UPPER_LAST) ? b + FOLD_DIST : b;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/lbs_match.sv
// Shift-and step of the literal byte search: byte compare, abort test and
// next partial match vector. Depends on lbs_pkg.
`default_nettype none

module lbs_match #(
    parameter int PM_W = lbs_pkg::LIT_BYTES
) (
    input  wire logic [PM_W-1:0]       i_pm,
    input  wire logic [7:0]            i_byte,
    input  wire logic                  i_ci,
    input  wire logic [lbs_pkg::LEN_W-1:0] i_len,
    input  wire logic                  i_aborted,
    input  wire logic [PM_W*8-1:0]     i_lit,
    output logic [PM_W-1:0]            o_pm_next,
    output lbs_pkg::t_match_flags      o_flags
);

    localparam int LW = lbs_pkg::LEN_W;

    logic [PM_W-1:0] eq;
    logic [PM_W-1:0] len_mask;
    logic [PM_W-1:0] last_mask;
    logic [7:0]      byte_cmp;
    logic            bad;
    logic            inject;

    always_comb begin
        byte_cmp = i_ci ? lbs_pkg::fold_byte(i_byte) : i_byte;
        for (int k = 0; k < PM_W; k++) begin
            eq[k] = i_ci ? (byte_cmp == lbs_pkg::fold_byte(i_lit[k*8 +: 8]))
                         : (byte_cmp == i_lit[k*8 +: 8]);
            len_mask[k]  = (LW'(k) < i_len);
            last_mask[k] = (LW'(k + 1) == i_len);
        end
    end

    assign bad    = (i_byte == 8'h00) || (i_ci && i_byte >= lbs_pkg::HIGH_BYTE);
    assign inject = !i_aborted && !bad && (i_len != '0);

    assign o_pm_next   = PM_W'({i_pm, inject}) & eq & len_mask;
    assign o_flags.hit = |(o_pm_next & last_mask);
    assign o_flags.bad = bad;

endmodule

`default_nettype wire

FILE: hdl/literal_byte_search_unit.sv
// Top level of the literal byte search unit: config registers, buffer state
// and a two-entry result holding stage. Depends on lbs_pkg and lbs_match.
//
//   channel   dir  payload                          transfer
//   s_axis    in   tdata[7:0] byte, tlast end       tvalid && tready
//   m_axis    out  tdata[31:0] offset, tuser kind,  tvalid && tready
//                  tlast final result
//   cfg       in   index[2:0], data[63:0]           i_cfg_valid && o_cfg_ready
//
// One byte per cycle while the holding stage has room; its results are
// registered and appear the next cycle. A match byte that ends the buffer
// holds two results; the input stalls while the second is held. Reset is
// synchronous, active low, and resets all but the result payloads; config
// is always ready. Output stalls reach s_axis_tready via the holding stage.
`default_nettype none

module literal_byte_search_unit #(
    parameter int MAX_LITERAL = lbs_pkg::MAX_LITERAL_DEF,
    parameter int OFFSET_BITS = lbs_pkg::OFFSET_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] match_offset
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [lbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lbs_pkg::WORD_W-1:0]    i_cfg_data
);

    localparam int PM_W = (MAX_LITERAL < lbs_pkg::LIT_BYTES) ? MAX_LITERAL
                                                              : lbs_pkg::LIT_BYTES;
    localparam int LW   = lbs_pkg::LEN_W;
    localparam int WW   = lbs_pkg::WORD_W;

    logic [LW-1:0]                      r_len;
    logic                               r_ci;
    logic [lbs_pkg::LIT_BYTES*8-1:0]    r_lit;

    logic [PM_W-1:0]        r_pm;
    logic [OFFSET_BITS-1:0] r_pos;
    logic                   r_abort;

    logic                   r_v0, r_v1;
    lbs_pkg::t_result       r_res0, r_res1;
    logic                   n_v0, n_v1;
    lbs_pkg::t_result       n_res0, n_res1;

    logic                   acc, pop;
    logic [LW-1:0]          len_eff;
    logic [PM_W-1:0]        pm_next;
    lbs_pkg::t_match_flags  flags;
    logic [OFFSET_BITS-1:0] lm1_ext;
    logic [OFFSET_BITS-1:0] start;
    logic [63:0]            start64;
    logic                   binary;
    lbs_pkg::t_result       res_match, res_stat;

    assign o_cfg_ready   = 1'b1;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign pop           = r_v0 && m_axis_tready;
    assign s_axis_tready = !r_v0 || (!r_v1 && m_axis_tready);

    assign len_eff = (r_len > LW'(PM_W)) ? LW'(PM_W) : r_len;

    lbs_match #(
        .PM_W (PM_W)
    ) u_match (
        .i_pm      (r_pm),
        .i_byte    (s_axis_tdata),
        .i_ci      (r_ci),
        .i_len     (len_eff),
        .i_aborted (r_abort),
        .i_lit     (r_lit[PM_W*8-1:0]),
        .o_pm_next (pm_next),
        .o_flags   (flags)
    );

    assign lm1_ext = OFFSET_BITS'(len_eff - LW'(1));
    assign start   = (r_pos >= lm1_ext) ? (r_pos - lm1_ext) : '0;
    assign start64 = 64'(start);
    assign binary  = r_abort || flags.bad || (len_eff == '0);

    always_comb begin
        res_match.kind   = lbs_pkg::KIND_MATCH;
        res_match.offset = start64[lbs_pkg::OUT_OFF_W-1:0];
        res_match.last   = 1'b0;
        res_stat.kind    = binary ? lbs_pkg::KIND_ABORT : lbs_pkg::KIND_CLEAN;
        res_stat.offset  = '0;
        res_stat.last    = 1'b1;
    end

    always_comb begin
        n_v0   = r_v0;
        n_v1   = r_v1;
        n_res0 = r_res0;
        n_res1 = r_res1;
        if (pop) begin
            n_v0   = r_v1;
            n_res0 = r_res1;
            n_v1   = 1'b0;
        end
        if (acc) begin
            n_v1 = 1'b0;
            if (flags.hit) begin
                n_v0   = 1'b1;
                n_res0 = res_match;
                if (s_axis_tlast) begin
                    n_v1   = 1'b1;
                    n_res1 = res_stat;
                end
            end else if (s_axis_tlast) begin
                n_v0   = 1'b1;
                n_res0 = res_stat;
            end else begin
                n_v0 = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LW'(1);
            r_ci    <= 1'b0;
            r_lit   <= '0;
            r_pm    <= '0;
            r_pos   <= '0;
            r_abort <= 1'b0;
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lbs_pkg::CFG_LITERAL_LENGTH:   r_len <= i_cfg_data[LW-1:0];
                    lbs_pkg::CFG_CASE_INSENSITIVE: r_ci <= i_cfg_data[0];
                    lbs_pkg::CFG_LIT_LOW:          r_lit[0*WW +: WW] <= i_cfg_data;
                    lbs_pkg::CFG_LIT_SECOND:       r_lit[1*WW +: WW] <= i_cfg_data;
                    lbs_pkg::CFG_LIT_THIRD:        r_lit[2*WW +: WW] <= i_cfg_data;
                    lbs_pkg::CFG_LIT_HIGH:         r_lit[3*WW +: WW] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (acc) begin
                if (s_axis_tlast) begin
                    r_pm    <= '0;
                    r_pos   <= '0;
                    r_abort <= 1'b0;
                end else begin
                    r_pm    <= pm_next;
                    r_abort <= r_abort || flags.bad;
                    if (r_pos != '1) begin
                        r_pos <= r_pos + OFFSET_BITS'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res0 <= n_res0;
        r_res1 <= n_res1;
    end

    assign m_axis_tvalid = r_v0;
    assign m_axis_tdata  = r_res0.offset;
    assign m_axis_tuser  = r_res0.kind;
    assign m_axis_tlast  = r_res0.last;

    a_hold_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_v0)
        else $error("second held result without a first");

    a_buffer_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && s_axis_tlast |=> (r_pos == '0) && (r_pm == '0) && !r_abort)
        else $error("buffer state not cleared after final byte");

    a_match_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v0 && (r_res0.kind == lbs_pkg::KIND_MATCH) |-> !r_res0.last)
        else $error("match result flagged as final");

    a_pos_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> r_pos == $past(r_pos))
        else $error("byte position moved without a transfer");

endmodule

`default_nettype wire
